### rtl/irms_pkg.sv
// Package for the infrared mark/space symbol encoder.
// Holds the constants, widths, command type and back-end state type.
// Used by every module of the block; depends on nothing.
package irms_pkg;

    localparam int BATCH_SYMBOLS = 64;
    localparam int MAX_TICKS     = 32767;
    localparam int TICK_RATE_HZ  = 1000000;
    localparam int MAX_OUT       = 16;
    localparam int SPACE_CAP     = 1000000;
    localparam int MARK_CAP      = 65535;
    localparam int KHZ_LIMIT     = 1000;
    localparam int KHZ_SCALE     = 1000;
    localparam int FLUSH_MARGIN  = 4;
    localparam int CARRIER_RESET = 38000;
    localparam int GAP_RESET     = 10000;

    localparam int DUR_W    = 20;
    localparam int MARK_W   = 16;
    localparam int TICK_W   = 15;
    localparam int SIB_W    = $clog2(BATCH_SYMBOLS + 1);
    localparam int SIBX_W   = SIB_W + 1;
    localparam int N_W      = $clog2(MAX_OUT + 1);
    localparam int PER_W    = $clog2(TICK_RATE_HZ / KHZ_SCALE + 1);
    localparam int DIVD_W   = DUR_W + 1;
    localparam int DIVS_W   = DUR_W;
    localparam int DCNT_W   = $clog2(DIVD_W + 1);
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 1'b1;

    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_SPACE = 1'b1;

    typedef struct packed {
        logic [MARK_W-1:0] mark_us;
        logic [DUR_W-1:0]  dur_us;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_MOD,
        ST_ADJ,
        ST_FIRST,
        ST_SPILL
    } back_state_t;

endpackage

### rtl/irms_front.sv
// Front end of the infrared symbol encoder: accepts input beats.
// Holds the pending mark and turns each space that follows a mark or is nonzero into a command for the queue.
// Depends on irms_pkg.
module irms_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [irms_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    input  logic                               cmd_full,
    output logic                               cmd_push,
    output irms_pkg::cmd_t                     cmd_data
);

    logic [irms_pkg::MARK_W-1:0] held_mark_reg, held_mark_next;
    logic                        mark_held_reg, mark_held_next;
    logic [irms_pkg::DUR_W-1:0]  dur_in;
    logic [irms_pkg::DUR_W-1:0]  space_sat;
    logic [irms_pkg::MARK_W-1:0] mark_sat;
    logic                        accept;

    assign s_tready = !cmd_full;
    assign accept   = s_tvalid && s_tready;
    assign dur_in   = s_tdata[irms_pkg::DUR_W-1:0];

    assign mark_sat  = (dur_in > irms_pkg::DUR_W'(irms_pkg::MARK_CAP)) ?
                       irms_pkg::MARK_W'(irms_pkg::MARK_CAP) : dur_in[irms_pkg::MARK_W-1:0];
    assign space_sat = (dur_in > irms_pkg::DUR_W'(irms_pkg::SPACE_CAP)) ?
                       irms_pkg::DUR_W'(irms_pkg::SPACE_CAP) : dur_in;

    always_comb begin
        held_mark_next   = held_mark_reg;
        mark_held_next   = mark_held_reg;
        cmd_push         = 1'b0;
        cmd_data.mark_us = mark_held_reg ? held_mark_reg : '0;
        cmd_data.dur_us  = space_sat;
        if (accept) begin
            if (s_tuser == irms_pkg::OP_MARK) begin
                if (dur_in != '0) begin
                    held_mark_next = mark_sat;
                    mark_held_next = 1'b1;
                end
            end else begin
                cmd_push       = mark_held_reg || (space_sat != '0);
                held_mark_next = '0;
                mark_held_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_mark_reg <= '0;
            mark_held_reg <= 1'b0;
        end else begin
            held_mark_reg <= held_mark_next;
            mark_held_reg <= mark_held_next;
        end
    end

endmodule

### rtl/irms_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// Lets either side stall on its own. Depends on irms_pkg.
module irms_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  irms_pkg::cmd_t push_data,
    input  logic           pop,
    output irms_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);

    irms_pkg::cmd_t                mem_reg [irms_pkg::FIFO_DEPTH];
    logic [irms_pkg::FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [irms_pkg::FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [irms_pkg::FIFO_CW-1:0]  count_reg, count_next;
    logic                          do_push, do_pop;

    assign full    = (count_reg == irms_pkg::FIFO_CW'(irms_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/irms_div.sv
// Restoring divider, one quotient bit per cycle.
// Shared by the carrier period and the mark remainder. Depends on irms_pkg.
module irms_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [irms_pkg::DIVD_W-1:0]   dividend,
    input  logic [irms_pkg::DIVS_W-1:0]   divisor,
    output logic                          done,
    output logic [irms_pkg::DIVD_W-1:0]   quotient,
    output logic [irms_pkg::DIVS_W-1:0]   remainder
);

    logic [irms_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [irms_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [irms_pkg::DIVS_W-1:0] dsr_reg, dsr_next;
    logic [irms_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [irms_pkg::DIVS_W:0]   trial;
    logic [irms_pkg::DIVS_W:0]   diff;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[irms_pkg::DIVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = irms_pkg::DCNT_W'(irms_pkg::DIVD_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[irms_pkg::DIVD_W-2:0], fits};
            rem_next = fits ? diff[irms_pkg::DIVS_W-1:0] : trial[irms_pkg::DIVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == irms_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/irms_back.sv
// Back end of the infrared symbol encoder: carries out one space command.
// Computes the carrier overshoot, spills long spaces and drives the output beat.
// Depends on irms_pkg and irms_div; holds the configuration registers.
module irms_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [irms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irms_pkg::DUR_W-1:0]         cfg_wdata,
    input  irms_pkg::cmd_t                     cmd_head,
    input  logic                               cmd_empty,
    output logic                               cmd_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [irms_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [irms_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                               m_tlast
);

    irms_pkg::back_state_t state_reg, state_next;

    logic [irms_pkg::DUR_W-1:0]  carrier_reg, carrier_next;
    logic [irms_pkg::DUR_W-1:0]  gap_reg, gap_next;
    logic [irms_pkg::MARK_W-1:0] mark_reg, mark_next;
    logic [irms_pkg::DUR_W-1:0]  dur_reg, dur_next;
    logic [irms_pkg::PER_W-1:0]  period_reg, period_next;
    logic [irms_pkg::PER_W-1:0]  over_reg, over_next;
    logic [irms_pkg::DUR_W-1:0]  rem_reg, rem_next;
    logic [irms_pkg::TICK_W-1:0] first_reg, first_next;
    logic [irms_pkg::N_W-1:0]    n_reg, n_next;
    logic [irms_pkg::SIB_W-1:0]  sib_reg, sib_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_level_reg, out_level_next;
    logic [irms_pkg::TICK_W-1:0] out_t0_reg, out_t0_next;
    logic [irms_pkg::TICK_W-1:0] out_t1_reg, out_t1_next;
    logic                        out_start_reg, out_start_next;
    logic                        out_end_reg, out_end_next;
    logic                        out_last_reg, out_last_next;

    logic                        out_free;
    logic                        emit;
    logic                        comp;
    logic                        div_start, div_done;
    logic [irms_pkg::DIVD_W-1:0] div_dividend, div_quo;
    logic [irms_pkg::DIVS_W-1:0] div_divisor, div_rem;

    logic [irms_pkg::DIVD_W-1:0] adj_sum;
    logic [irms_pkg::DUR_W-1:0]  adj;
    logic [irms_pkg::DUR_W-1:0]  adj_first;
    logic [irms_pkg::DUR_W-1:0]  d0, r1, d1, r2;
    logic [irms_pkg::N_W-1:0]    n_inc;
    logic                        spill_last;
    logic                        first_last;
    logic                        gap_hit;
    logic                        pre_flush;
    logic                        spill_flush;
    logic [irms_pkg::SIB_W-1:0]  sib_base;
    logic                        sym_last;

    localparam logic [irms_pkg::DUR_W-1:0] MAX_T = irms_pkg::DUR_W'(irms_pkg::MAX_TICKS);

    irms_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign comp     = (cmd_head.mark_us != '0) && (cmd_head.dur_us != '0) &&
                      (carrier_reg != '0);

    assign adj_sum   = {1'b0, dur_reg} + irms_pkg::DIVD_W'(over_reg);
    assign adj       = (adj_sum > irms_pkg::DIVD_W'(irms_pkg::SPACE_CAP)) ?
                       irms_pkg::DUR_W'(irms_pkg::SPACE_CAP) : adj_sum[irms_pkg::DUR_W-1:0];
    assign adj_first = (adj > MAX_T) ? MAX_T : adj;

    assign d0         = (rem_reg > MAX_T) ? MAX_T : rem_reg;
    assign r1         = rem_reg - d0;
    assign d1         = (r1 > MAX_T) ? MAX_T : r1;
    assign r2         = r1 - d1;
    assign n_inc      = n_reg + 1'b1;
    assign spill_last = (r2 == '0) || (n_inc == irms_pkg::N_W'(irms_pkg::MAX_OUT));
    assign first_last = (rem_reg == '0);
    assign gap_hit    = (dur_reg >= gap_reg);

    assign pre_flush   = ({1'b0, sib_reg} + irms_pkg::SIBX_W'(irms_pkg::FLUSH_MARGIN)) >=
                         irms_pkg::SIBX_W'(irms_pkg::BATCH_SYMBOLS);
    assign spill_flush = ({1'b0, sib_reg} + irms_pkg::SIBX_W'(1)) >=
                         irms_pkg::SIBX_W'(irms_pkg::BATCH_SYMBOLS);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            irms_pkg::ST_IDLE: begin
                if (!cmd_empty) begin
                    state_next = comp ? irms_pkg::ST_PERIOD : irms_pkg::ST_ADJ;
                end
            end
            irms_pkg::ST_PERIOD: begin
                if (div_done) begin
                    state_next = irms_pkg::ST_MOD;
                end
            end
            irms_pkg::ST_MOD: begin
                if (div_done) begin
                    state_next = irms_pkg::ST_ADJ;
                end
            end
            irms_pkg::ST_ADJ: begin
                state_next = irms_pkg::ST_FIRST;
            end
            irms_pkg::ST_FIRST: begin
                if (out_free) begin
                    state_next = first_last ? irms_pkg::ST_IDLE : irms_pkg::ST_SPILL;
                end
            end
            irms_pkg::ST_SPILL: begin
                if (out_free && spill_last) begin
                    state_next = irms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = irms_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        cmd_pop      = 1'b0;
        div_start    = 1'b0;
        emit         = 1'b0;
        div_dividend = irms_pkg::DIVD_W'(irms_pkg::TICK_RATE_HZ) +
                       irms_pkg::DIVD_W'(carrier_reg) - irms_pkg::DIVD_W'(1);
        div_divisor  = carrier_reg;
        unique case (state_reg)
            irms_pkg::ST_IDLE: begin
                cmd_pop   = !cmd_empty;
                div_start = !cmd_empty && comp;
            end
            irms_pkg::ST_PERIOD: begin
                div_start    = div_done;
                div_dividend = irms_pkg::DIVD_W'(mark_reg);
                div_divisor  = irms_pkg::DIVS_W'(div_quo[irms_pkg::PER_W-1:0]);
            end
            irms_pkg::ST_FIRST, irms_pkg::ST_SPILL: begin
                emit = out_free;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb begin
        carrier_next   = carrier_reg;
        gap_next       = gap_reg;
        mark_next      = mark_reg;
        dur_next       = dur_reg;
        period_next    = period_reg;
        over_next      = over_reg;
        rem_next       = rem_reg;
        first_next     = first_reg;
        n_next         = n_reg;
        sib_next       = sib_reg;
        out_level_next = out_level_reg;
        out_t0_next    = out_t0_reg;
        out_t1_next    = out_t1_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        sib_base       = sib_reg;
        sym_last       = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                irms_pkg::CFG_CARRIER: begin
                    carrier_next = (cfg_wdata < irms_pkg::DUR_W'(irms_pkg::KHZ_LIMIT)) ?
                                   irms_pkg::DUR_W'(cfg_wdata *
                                                    irms_pkg::DUR_W'(irms_pkg::KHZ_SCALE)) :
                                   cfg_wdata;
                end
                irms_pkg::CFG_GAP: begin
                    gap_next = cfg_wdata;
                end
                default: begin
                    gap_next = gap_reg;
                end
            endcase
        end

        unique case (state_reg)
            irms_pkg::ST_IDLE: begin
                if (!cmd_empty) begin
                    mark_next = cmd_head.mark_us;
                    dur_next  = cmd_head.dur_us;
                    over_next = '0;
                end
            end
            irms_pkg::ST_PERIOD: begin
                if (div_done) begin
                    period_next = div_quo[irms_pkg::PER_W-1:0];
                end
            end
            irms_pkg::ST_MOD: begin
                if (div_done) begin
                    over_next = (div_rem == '0) ? '0 :
                                period_reg - div_rem[irms_pkg::PER_W-1:0];
                end
            end
            irms_pkg::ST_ADJ: begin
                first_next = adj_first[irms_pkg::TICK_W-1:0];
                rem_next   = adj - adj_first;
            end
            irms_pkg::ST_FIRST: begin
                if (emit) begin
                    sib_base       = pre_flush ? '0 : sib_reg;
                    sym_last       = first_last;
                    out_level_next = 1'b1;
                    out_t0_next    = (mark_reg > irms_pkg::MARK_W'(irms_pkg::MAX_TICKS)) ?
                                     irms_pkg::TICK_W'(irms_pkg::MAX_TICKS) :
                                     mark_reg[irms_pkg::TICK_W-1:0];
                    out_t1_next    = first_reg;
                    out_start_next = pre_flush;
                    n_next         = irms_pkg::N_W'(1);
                end
            end
            irms_pkg::ST_SPILL: begin
                if (emit) begin
                    sib_base       = spill_flush ? '0 : sib_reg;
                    sym_last       = spill_last;
                    out_level_next = 1'b0;
                    out_t0_next    = d0[irms_pkg::TICK_W-1:0];
                    out_t1_next    = d1[irms_pkg::TICK_W-1:0];
                    out_start_next = spill_flush;
                    rem_next       = r2;
                    n_next         = n_inc;
                end
            end
            default: begin
                sib_base = sib_reg;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
            out_last_next  = sym_last;
            out_end_next   = sym_last && gap_hit;
            sib_next       = (sym_last && gap_hit) ? '0 : sib_base + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        mark_reg      <= mark_next;
        dur_reg       <= dur_next;
        period_reg    <= period_next;
        over_reg      <= over_next;
        rem_reg       <= rem_next;
        first_reg     <= first_next;
        n_reg         <= n_next;
        out_level_reg <= out_level_next;
        out_t0_reg    <= out_t0_next;
        out_t1_reg    <= out_t1_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= irms_pkg::ST_IDLE;
            carrier_reg   <= irms_pkg::DUR_W'(irms_pkg::CARRIER_RESET);
            gap_reg       <= irms_pkg::DUR_W'(irms_pkg::GAP_RESET);
            sib_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            carrier_reg   <= carrier_next;
            gap_reg       <= gap_next;
            sib_reg       <= sib_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_t1_reg, out_t0_reg, out_level_reg};
    assign m_tuser  = {out_end_reg, out_start_reg};
    assign m_tlast  = out_last_reg;

endmodule

### rtl/ir_mark_space_symbol_encoder.sv
// Top level of the infrared mark/space symbol encoder.
// Instantiates irms_front, irms_cmd_fifo and irms_back; depends on irms_pkg.
//
//   Channel   Direction  Beat content
//   s_        in         tuser: opcode; tdata: duration_us
//   m_        out        tdata: symbol halves; tuser: batch flags; tlast: last symbol
//   cfg_      in         register write, index 0 carrier, 1 gap threshold
//
// A mark beat is held in the front end, taken whenever the queue is not full.
// A space with carrier compensation passes through the back end as one pop
// step, two 21-step divisions and one adjust step, plus one step per symbol;
// without compensation the divisions are skipped. Output stalls hold symbols.
// The two-entry command queue lets the front end keep taking beats while the
// back end works or the output stalls. Reset is synchronous, active low.
module ir_mark_space_symbol_encoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [irms_pkg::IN_TDATA_W-1:0]    s_tdata,   // [19:0] duration_us
    input  logic                               s_tuser,   // [0] opcode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [irms_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [0] first_level, [15:1] first_ticks,
                                                          // [30:16] second_ticks
    output logic [irms_pkg::OUT_TUSER_W-1:0]   m_tuser,   // [0] batch_start, [1] batch_end
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [irms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irms_pkg::DUR_W-1:0]         cfg_wdata
);

    logic           cmd_push, cmd_pop, cmd_full, cmd_empty;
    irms_pkg::cmd_t cmd_in, cmd_head;

    irms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in)
    );

    irms_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .full      (cmd_full),
        .empty     (cmd_empty)
    );

    irms_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_head  (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### rtl/irms_chk.sv
// Port-level checker for the infrared mark/space symbol encoder.
// Bound to ir_mark_space_symbol_encoder; depends on irms_pkg.
module irms_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [irms_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic [irms_pkg::OUT_TUSER_W-1:0]   m_tuser,
    input logic                               m_tlast
);

    logic after_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_last_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            after_last_reg <= m_tlast;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Output beat valid right after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled output beat changed.");

    a_first_is_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && after_last_reg |-> m_tdata[0])
        else $error("First symbol of an input is not a mark symbol.");

    a_gap_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("Gap flush flag on a symbol that is not the last.");

    a_spill_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[15:1] != '0)
        else $error("Spill symbol with an empty first half.");

endmodule

bind ir_mark_space_symbol_encoder irms_chk u_irms_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
